FILE: hdl/ppe_pkg.sv
// Package: shared constants, types and command/status structs of the piecewise polynomial evaluator.
package ppe_pkg;
	localparam int MaxBreaks = 64;
	localparam int MaxOrder = 8;
	localparam logic [1:0] OP_LOAD_BREAK = 2'd0;
	localparam logic [1:0] OP_LOAD_COEF = 2'd1;
	localparam logic [1:0] OP_EVAL = 2'd2;
	localparam logic [1:0] OP_NOP = 2'd3;
	localparam logic [7:0] REG_BREAKS = 8'd0;
	localparam logic [7:0] REG_ORDER = 8'd1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_CHK0 = 9'b000000010,
		ST_CHKN = 9'b000000100,
		ST_PROBE = 9'b000001000,
		ST_WAIT = 9'b000010000,
		ST_DELTA = 9'b000100000,
		ST_MUL = 9'b001000000,
		ST_ADD = 9'b010000000,
		ST_OUT = 9'b100000000
	} state_t;

	typedef struct packed {
		logic start;
		logic rd_first;
		logic rd_last;
		logic rd_mid;
		logic cmp_first;
		logic cmp_last;
		logic cmp_mid;
		logic do_delta;
		logic rd_coef;
		logic do_mul;
		logic do_add;
	} cmd_t;

	typedef struct packed {
		logic search_done;
		logic last_term;
	} sts_t;
endpackage

FILE: hdl/ppe_ctrl.sv
// Controller: sequences search, delta and Horner steps for one evaluate transaction.
module ppe_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic eval_start,
	input  ppe_pkg::sts_t sts,
	input  logic out_ready,
	output ppe_pkg::cmd_t cmd,
	output logic busy,
	output logic out_valid
);
	ppe_pkg::state_t state_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ppe_pkg::ST_IDLE;
		else state_q <= nxt;
	end

	always_comb begin
		nxt = state_q;
		cmd = '0;
		case (state_q)
			ppe_pkg::ST_IDLE: begin
				if (eval_start) begin
					cmd.start = 1'b1;
					cmd.rd_first = 1'b1;
					nxt = ppe_pkg::ST_CHK0;
				end
			end
			ppe_pkg::ST_CHK0: begin
				cmd.cmp_first = 1'b1;
				cmd.rd_last = 1'b1;
				nxt = ppe_pkg::ST_CHKN;
			end
			ppe_pkg::ST_CHKN: begin
				cmd.cmp_last = 1'b1;
				nxt = ppe_pkg::ST_PROBE;
			end
			ppe_pkg::ST_PROBE: begin
				if (sts.search_done) nxt = ppe_pkg::ST_DELTA;
				else begin
					cmd.rd_mid = 1'b1;
					nxt = ppe_pkg::ST_WAIT;
				end
			end
			ppe_pkg::ST_WAIT: begin
				cmd.cmp_mid = 1'b1;
				nxt = ppe_pkg::ST_PROBE;
			end
			ppe_pkg::ST_DELTA: begin
				cmd.do_delta = 1'b1;
				cmd.rd_coef = 1'b1;
				nxt = sts.last_term ? ppe_pkg::ST_OUT : ppe_pkg::ST_MUL;
			end
			ppe_pkg::ST_MUL: begin
				cmd.do_mul = 1'b1;
				cmd.rd_coef = 1'b1;
				nxt = ppe_pkg::ST_ADD;
			end
			ppe_pkg::ST_ADD: begin
				cmd.do_add = 1'b1;
				nxt = sts.last_term ? ppe_pkg::ST_OUT : ppe_pkg::ST_MUL;
			end
			ppe_pkg::ST_OUT: begin
				if (out_ready) nxt = ppe_pkg::ST_IDLE;
			end
			default: nxt = ppe_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != ppe_pkg::ST_IDLE);
	assign out_valid = (state_q == ppe_pkg::ST_OUT);
endmodule

FILE: hdl/ppe_datapath.sv
// Datapath: break and coefficient memories, bisection registers and Horner arithmetic.
module ppe_datapath #(
	parameter int MAX_BREAKS = ppe_pkg::MaxBreaks,
	parameter int MAX_ORDER = ppe_pkg::MaxOrder
) (
	input  logic clk,
	input  logic arst_n,
	input  logic brk_we,
	input  logic coef_we,
	input  logic [5:0] entry_index,
	input  logic [2:0] term_index,
	input  logic signed [31:0] value,
	input  logic [$clog2(MAX_BREAKS+1)-1:0] n_brk,
	input  logic [$clog2(MAX_ORDER+1)-1:0] n_ord,
	input  ppe_pkg::cmd_t cmd,
	output ppe_pkg::sts_t sts,
	output logic signed [31:0] result,
	output logic [5:0] segment,
	output logic saturated
);
	localparam int BW = $clog2(MAX_BREAKS);
	localparam int CW = $clog2((MAX_BREAKS-1)*MAX_ORDER);
	localparam int NW = $clog2(MAX_BREAKS+1);
	localparam int KW = $clog2(MAX_ORDER+1);

	logic signed [31:0] brk_mem [MAX_BREAKS];
	logic signed [31:0] coef_mem [(MAX_BREAKS-1)*MAX_ORDER];
	logic signed [31:0] brk_rd_q, coef_rd_q, x_q, delta_q, acc_q;
	logic [BW-1:0] lo_q, hi_q, brk_addr, mid;
	logic [BW:0] mid_sum;
	logic [KW-1:0] k_q;
	logic pinned_q, flag_q;
	logic signed [63:0] prod_q;
	logic [CW-1:0] coef_addr, wr_addr;
	logic signed [32:0] dsum;
	logic signed [48:0] rnd;
	logic signed [49:0] asum;
	logic signed [31:0] dsat, asat;
	logic dovf, aovf;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[BW:1];
	always_comb begin
		brk_addr = lo_q;
		if (cmd.rd_first) brk_addr = '0;
		else if (cmd.rd_last) brk_addr = BW'(n_brk - NW'(1));
		else if (cmd.rd_mid) brk_addr = mid;
	end
	assign wr_addr = CW'(entry_index) * CW'(MAX_ORDER) + CW'(term_index);
	assign coef_addr = CW'(lo_q) * CW'(MAX_ORDER) + CW'(k_q);

	always_ff @(posedge clk) begin
		if (brk_we && 32'(entry_index) < 32'(MAX_BREAKS)) brk_mem[BW'(entry_index)] <= value;
		if (coef_we && 32'(entry_index) < 32'(MAX_BREAKS-1) && 32'(term_index) < 32'(MAX_ORDER))
			coef_mem[wr_addr] <= value;
		brk_rd_q <= brk_mem[brk_addr];
		coef_rd_q <= coef_mem[coef_addr];
	end

	assign dsum = 33'(x_q) - 33'(brk_rd_q);
	assign dovf = (dsum[32] != dsum[31]);
	assign dsat = dovf ? (dsum[32] ? 32'sh80000000 : 32'sh7fffffff) : dsum[31:0];
	assign rnd = 49'((prod_q + 64'sd32768) >>> 16);
	assign asum = 50'(rnd) + 50'(coef_rd_q);
	assign aovf = (asum > 50'sd2147483647) || (asum < -50'sd2147483648);
	assign asat = aovf ? (asum[49] ? 32'sh80000000 : 32'sh7fffffff) : asum[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pinned_q <= 1'b0;
			flag_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
			k_q <= '0;
			x_q <= '0;
			delta_q <= '0;
			acc_q <= '0;
			prod_q <= '0;
		end else begin
			if (cmd.start) begin
				x_q <= value;
				lo_q <= '0;
				hi_q <= BW'(n_brk - NW'(1));
				pinned_q <= 1'b0;
				flag_q <= 1'b0;
				k_q <= '0;
			end
			if (cmd.cmp_first && x_q <= brk_rd_q) begin
				pinned_q <= 1'b1;
				lo_q <= '0;
			end
			if (cmd.cmp_last && !pinned_q && x_q > brk_rd_q) begin
				pinned_q <= 1'b1;
				lo_q <= BW'(n_brk - NW'(2));
			end
			if (cmd.cmp_mid && !pinned_q) begin
				if (brk_rd_q >= x_q) hi_q <= mid;
				else lo_q <= mid;
			end
			if (cmd.do_delta) begin
				delta_q <= dsat;
				flag_q <= dovf;
				acc_q <= coef_rd_q;
				k_q <= KW'(1);
			end
			if (cmd.do_mul) begin
				prod_q <= 64'(delta_q) * 64'(acc_q);
			end
			if (cmd.do_add) begin
				acc_q <= asat;
				flag_q <= flag_q | aovf;
				k_q <= k_q + KW'(1);
			end
		end
	end

	assign sts.search_done = pinned_q || (hi_q - lo_q <= BW'(1));
	assign sts.last_term = (k_q >= n_ord) || (cmd.do_delta && n_ord == KW'(1))
		|| (cmd.do_add && (k_q + KW'(1)) >= n_ord);
	assign result = acc_q;
	assign segment = 6'(lo_q);
	assign saturated = flag_q;
endmodule

FILE: hdl/piecewise_polynomial_eval.sv
// An accepted evaluate transaction checks the first and last breaks, then runs up to
// ceil(log2(breaks-1)) bisection probes (none when x is at or below the first break or
// above the last), then the delta and the Horner terms before valid_out. Each probe is a
// memory read and a compare, each further Horner term a multiply and an add; one evaluation
// at a time, next input accepted in the cycle after the result is taken. Loads only while idle.
// Reset (arst_n, asynchronous): controller idle, breaks_in_use 2, order_in_use 4; tables undefined.
module piecewise_polynomial_eval #(
	parameter int MAX_BREAKS = ppe_pkg::MaxBreaks,
	parameter int MAX_ORDER = ppe_pkg::MaxOrder
) (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_in,
	output logic ready_in,
	input  logic [1:0] op,
	input  logic [5:0] entry_index,
	input  logic [2:0] term_index,
	input  logic signed [31:0] value,
	output logic valid_out,
	input  logic ready_out,
	output logic signed [31:0] result,
	output logic [5:0] segment,
	output logic saturated,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int NW = $clog2(MAX_BREAKS+1);
	localparam int KW = $clog2(MAX_ORDER+1);

	logic [6:0] breaks_q;
	logic [3:0] order_q;
	logic [NW-1:0] n_brk;
	logic [KW-1:0] n_ord;
	logic busy, acc_in, wr;
	logic [7:0] reg_idx;
	logic [6:0] bv;
	logic [3:0] ov;
	ppe_pkg::cmd_t cmd;
	ppe_pkg::sts_t sts;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign reg_idx = {7'd0, paddr[2]};
	assign bv = pwdata[6:0];
	assign ov = pwdata[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			breaks_q <= 7'd2;
			order_q <= 4'd4;
		end else if (wr && paddr[1:0] == 2'd0) begin
			if (reg_idx == ppe_pkg::REG_BREAKS)
				breaks_q <= (bv < 7'd2) ? 7'd2 :
					(32'(bv) > 32'(MAX_BREAKS) ? 7'(MAX_BREAKS) : bv);
			else if (reg_idx == ppe_pkg::REG_ORDER)
				order_q <= (ov < 4'd1) ? 4'd1 :
					(32'(ov) > 32'(MAX_ORDER) ? 4'(MAX_ORDER) : ov);
		end
	end

	always_comb begin
		case (reg_idx)
			ppe_pkg::REG_BREAKS: prdata = {25'd0, breaks_q};
			ppe_pkg::REG_ORDER: prdata = {28'd0, order_q};
			default: prdata = '0;
		endcase
	end

	assign n_brk = NW'(breaks_q);
	assign n_ord = KW'(order_q);
	assign ready_in = !busy;
	assign acc_in = valid_in && ready_in;

	ppe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.eval_start(acc_in && op == ppe_pkg::OP_EVAL),
		.sts(sts), .out_ready(ready_out),
		.cmd(cmd), .busy(busy), .out_valid(valid_out)
	);

	ppe_datapath #(.MAX_BREAKS(MAX_BREAKS), .MAX_ORDER(MAX_ORDER)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.brk_we(acc_in && op == ppe_pkg::OP_LOAD_BREAK),
		.coef_we(acc_in && op == ppe_pkg::OP_LOAD_COEF),
		.entry_index(entry_index), .term_index(term_index), .value(value),
		.n_brk(n_brk), .n_ord(n_ord), .cmd(cmd), .sts(sts),
		.result(result), .segment(segment), .saturated(saturated)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && !ready_out |=> valid_out && $stable(result) && $stable(segment))
		else $error("result changed while stalled");
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> !ready_in)
		else $error("input taken while result pending");
	a_seg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> 32'(segment) <= 32'(breaks_q) - 2)
		else $error("segment out of range");
endmodule

FILE: tb/sv/tb_piecewise_polynomial_eval.sv
// Testbench for piecewise_polynomial_eval: table loads, segment search and Horner checks.
`timescale 1ns / 100ps
module tb_piecewise_polynomial_eval;
	typedef struct {
		logic signed [31:0] res;
		logic [5:0] seg;
		logic sat;
	} poly_out_t;

	typedef struct {
		logic [1:0] op;
		logic [5:0] ent;
		logic [2:0] term;
		logic [31:0] val;
		bit typed;
		logic [31:0] res;
		logic [5:0] seg;
		logic sat;
	} stim_row_t;

	localparam int EvalLatency = 40;

	logic clk = 0;
	logic arst_n = 0;
	logic valid_in = 0;
	logic ready_in;
	logic [1:0] op = '0;
	logic [5:0] entry_index = '0;
	logic [2:0] term_index = '0;
	logic signed [31:0] value = '0;
	logic valid_out;
	logic ready_out = 0;
	logic signed [31:0] result;
	logic [5:0] segment;
	logic saturated;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	piecewise_polynomial_eval dut (.*);

	always #5 clk = ~clk;

	logic signed [31:0] break_mem [ppe_pkg::MaxBreaks];
	logic signed [31:0] coef_mem [ppe_pkg::MaxBreaks-1][ppe_pkg::MaxOrder];
	int unsigned breaks_cfg = 2;
	int unsigned order_cfg = 4;
	poly_out_t pending_q [$];
	int errors = 0;
	int n_eval = 0;
	int n_load = 0;
	int n_cfg = 0;
	int n_seen = 0;
	bit gaps_on = 1;
	bit stalls_on = 1;

	function automatic longint clip32(longint v, inout logic flag);
		if (v > 64'sd2147483647) begin
			flag = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			flag = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic poly_out_t horner_eval(logic signed [31:0] x);
		int unsigned n, lo, hi, mid, s, k;
		logic flag;
		longint d, acc;
		poly_out_t r;
		n = breaks_cfg;
		flag = 0;
		if (x <= break_mem[0]) begin
			s = 0;
		end else if (x > break_mem[n-1]) begin
			s = n - 2;
		end else begin
			lo = 0;
			hi = n - 1;
			while (hi - lo > 1) begin
				mid = (lo + hi) / 2;
				if (break_mem[mid] >= x) hi = mid;
				else lo = mid;
			end
			s = lo;
		end
		d = clip32(longint'(x) - longint'(break_mem[s]), flag);
		acc = longint'(coef_mem[s][0]);
		for (k = 1; k < order_cfg; k++)
			acc = clip32(((d * acc + 32768) >>> 16) + longint'(coef_mem[s][k]), flag);
		r.res = acc[31:0];
		r.seg = s[5:0];
		r.sat = flag;
		return r;
	endfunction

	function automatic poly_out_t apply_item(logic [1:0] o, logic [5:0] e, logic [2:0] t,
			logic signed [31:0] v);
		poly_out_t r;
		r = '{default: '0};
		case (o)
			ppe_pkg::OP_LOAD_BREAK: break_mem[e] = v;
			ppe_pkg::OP_LOAD_COEF: if (e < ppe_pkg::MaxBreaks - 1) coef_mem[e][t] = v;
			ppe_pkg::OP_EVAL: r = horner_eval(v);
			default: ;
		endcase
		return r;
	endfunction

	task automatic send(logic [1:0] o, logic [5:0] e, logic [2:0] t, logic [31:0] v,
			bit typed = 0, poly_out_t want = '{default: '0});
		int gap;
		poly_out_t p;
		gap = gaps_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			valid_in <= 0;
			repeat (gap) @(posedge clk);
		end
		valid_in <= 1;
		op <= o;
		entry_index <= e;
		term_index <= t;
		value <= v;
		do @(posedge clk); while (!ready_in);
		p = apply_item(o, e, t, v);
		if (o == ppe_pkg::OP_EVAL) begin
			pending_q.push_back(typed ? want : p);
			n_eval++;
		end else begin
			n_load++;
		end
	endtask

	task automatic drain();
		valid_in <= 0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (EvalLatency) @(posedge clk);
	endtask

	task automatic reg_write(logic [7:0] idx, logic [31:0] data);
		logic [31:0] v;
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 3'(idx * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == ppe_pkg::REG_BREAKS) begin
			v = data & 32'h7F;
			breaks_cfg = v < 2 ? 2 : (v > ppe_pkg::MaxBreaks ? ppe_pkg::MaxBreaks : v);
		end else if (idx == ppe_pkg::REG_ORDER) begin
			v = data & 32'hF;
			order_cfg = v < 1 ? 1 : (v > ppe_pkg::MaxOrder ? ppe_pkg::MaxOrder : v);
		end
		n_cfg++;
	endtask

	function automatic logic [31:0] rand_coef();
		if ($urandom_range(0, 1)) return 32'($urandom_range(0, 32'h40000)) - 32'h20000;
		return $urandom;
	endfunction

	task automatic fill_tables(bit ordered);
		logic signed [31:0] b;
		b = 32'($urandom_range(0, 32'h80000000)) - 32'h40000000;
		for (int i = 0; i < breaks_cfg; i++) begin
			send(ppe_pkg::OP_LOAD_BREAK, 6'(i), 3'($urandom), ordered ? b : $urandom);
			b = b + 32'($urandom_range(1, 32'h100000));
		end
		for (int s = 0; s < breaks_cfg - 1; s++)
			for (int t = 0; t < order_cfg; t++)
				send(ppe_pkg::OP_LOAD_COEF, 6'(s), 3'(t), rand_coef());
	endtask

	function automatic logic [31:0] rand_x();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			2: return break_mem[$urandom_range(0, breaks_cfg - 1)];
			default: return break_mem[$urandom_range(0, breaks_cfg - 1)]
				+ 32'($urandom_range(0, 32'h200000)) - 32'h100000;
		endcase
	endfunction

	task automatic random_items(int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 19) == 0) gaps_on = !gaps_on;
			pick = $urandom_range(0, 19);
			if (pick < 13)
				send(ppe_pkg::OP_EVAL, 6'($urandom), 3'($urandom), rand_x());
			else if (pick < 15)
				send(ppe_pkg::OP_LOAD_BREAK, 6'($urandom), 3'($urandom), $urandom);
			else if (pick < 19)
				send(ppe_pkg::OP_LOAD_COEF, 6'($urandom), 3'($urandom), rand_coef());
			else send(ppe_pkg::OP_NOP, 6'($urandom), 3'($urandom), $urandom);
		end
	endtask

	stim_row_t directed [] = '{
		'{ppe_pkg::OP_LOAD_BREAK, 6'd0, 3'd0, 32'h00010000, 0, 0, 0, 0},
		'{ppe_pkg::OP_LOAD_BREAK, 6'd1, 3'd0, 32'h00020000, 0, 0, 0, 0},
		'{ppe_pkg::OP_LOAD_COEF, 6'd0, 3'd0, 32'h00000000, 0, 0, 0, 0},
		'{ppe_pkg::OP_LOAD_COEF, 6'd0, 3'd1, 32'h00000000, 0, 0, 0, 0},
		'{ppe_pkg::OP_LOAD_COEF, 6'd0, 3'd2, 32'h00000000, 0, 0, 0, 0},
		'{ppe_pkg::OP_LOAD_COEF, 6'd0, 3'd3, 32'h7FFFFFFF, 0, 0, 0, 0},
		'{ppe_pkg::OP_EVAL, 6'd0, 3'd0, 32'h80000000, 1, 32'h7FFFFFFF, 6'd0, 1'b1},
		'{ppe_pkg::OP_EVAL, 6'd63, 3'd7, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 6'd0, 1'b0},
		'{ppe_pkg::OP_EVAL, 6'd0, 3'd0, 32'h00018000, 1, 32'h7FFFFFFF, 6'd0, 1'b0},
		'{ppe_pkg::OP_EVAL, 6'd0, 3'd0, 32'h00010000, 1, 32'h7FFFFFFF, 6'd0, 1'b0},
		'{ppe_pkg::OP_NOP, 6'd5, 3'd5, 32'hDEADBEEF, 0, 0, 0, 0},
		'{ppe_pkg::OP_LOAD_COEF, 6'd63, 3'd7, 32'h12345678, 0, 0, 0, 0},
		'{ppe_pkg::OP_LOAD_BREAK, 6'd63, 3'd0, 32'hFFFFFFFF, 0, 0, 0, 0},
		'{ppe_pkg::OP_EVAL, 6'd0, 3'd0, 32'h00020000, 1, 32'h7FFFFFFF, 6'd0, 1'b0},
		'{ppe_pkg::OP_LOAD_COEF, 6'd0, 3'd0, 32'h7FFFFFFF, 0, 0, 0, 0},
		'{ppe_pkg::OP_LOAD_COEF, 6'd0, 3'd1, 32'h7FFFFFFF, 0, 0, 0, 0},
		'{ppe_pkg::OP_EVAL, 6'd0, 3'd0, 32'h7FFFFFFF, 0, 0, 0, 0},
		'{ppe_pkg::OP_LOAD_COEF, 6'd0, 3'd0, 32'h80000000, 0, 0, 0, 0},
		'{ppe_pkg::OP_EVAL, 6'd0, 3'd0, 32'h7FFFFFFF, 0, 0, 0, 0},
		'{ppe_pkg::OP_LOAD_COEF, 6'd0, 3'd3, 32'h80000000, 0, 0, 0, 0},
		'{ppe_pkg::OP_EVAL, 6'd0, 3'd0, 32'h80000000, 0, 0, 0, 0},
		'{ppe_pkg::OP_EVAL, 6'd0, 3'd0, 32'h00015555, 0, 0, 0, 0}
	};

	initial begin
		int stall;
		poly_out_t want;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0) stalls_on = !stalls_on;
			stall = stalls_on ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				ready_out <= 0;
				repeat (stall) @(posedge clk);
			end
			ready_out <= 1;
			do @(posedge clk); while (!valid_out);
			n_seen++;
			if (pending_q.size() == 0) begin
				$display("%0t: result with nothing pending: result %h segment %0d sat %b",
					$time, result, segment, saturated);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (result !== want.res || segment !== want.seg || saturated !== want.sat) begin
					$display("%0t: mismatch expected %h/%0d/%b actual %h/%0d/%b", $time,
						want.res, want.seg, want.sat, result, segment, saturated);
					errors++;
				end
			end
		end
	end

	initial begin
		poly_out_t want;
		int unsigned bcfg [8] = '{0, 127, 3, 5, 12, 7, 2, 9};
		int unsigned ocfg [8] = '{15, 1, 0, 8, 3, 2, 6, 5};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) begin
			want.res = directed[i].res;
			want.seg = directed[i].seg;
			want.sat = directed[i].sat;
			send(directed[i].op, directed[i].ent, directed[i].term, directed[i].val,
				directed[i].typed, want);
		end
		for (int p = 0; p < 8; p++) begin
			drain();
			reg_write(ppe_pkg::REG_BREAKS, bcfg[p] | ($urandom & 32'hFFFFFF80));
			reg_write(ppe_pkg::REG_ORDER, ocfg[p] | ($urandom & 32'hFFFFFFF0));
			gaps_on = 1;
			fill_tables(p % 4 != 3);
			random_items(35);
		end
		drain();
		$display("Covered %0d evaluations, %0d loads and %0d register writes;", n_eval,
			n_load, n_cfg);
		$display("%0d results checked over orders 1 to 8 and 2 to 64 breakpoints.", n_seen);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("piecewise_polynomial_eval verification clean");
		end else begin
			$display("piecewise_polynomial_eval verification failed");
		end
		$finish;
	end

	initial begin
		#30ms;
		$display("piecewise_polynomial_eval verification failed");
		$finish;
	end
endmodule

FILE: files.f
hdl/ppe_pkg.sv
hdl/ppe_ctrl.sv
hdl/ppe_datapath.sv
hdl/piecewise_polynomial_eval.sv
tb/sv/tb_piecewise_polynomial_eval.sv
